// ===== sv/drob_pkg.sv =====
// ----------------------------------------------------------------------------
// drob_pkg: shared types and constants for the downward ray box hit unit
// Register indexes, datapath widths and the records that travel between the
// front end, the divider cells and the slab back end.
// ----------------------------------------------------------------------------
package drob_pkg;

  localparam int COORD_WIDTH_DEFAULT = 32;

  // Q2.14 one
  localparam int ONE_Q14 = 16384;

  // Divider: numerator magnitude, remainder and divisor widths
  localparam int NUM_W = 49;
  localparam int REM_W = 16;
  localparam int DIV_W = 15;

  // Signed slab distance width
  localparam int T_W = NUM_W + 1;

  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [2:0] REG_RAY_LENGTH  = 3'd3;
  localparam logic [2:0] REG_FOOT_RADIUS = 3'd4;

  localparam logic [1:0] AXIS_NONE = 2'd3;

  // Two lanes per box axis: even lane is the minus-side plane, odd lane the plus side
  typedef struct packed {
    logic [5:0][NUM_W-1:0] num;
    logic [5:0][REM_W-1:0] rem;
    logic [2:0][DIV_W-1:0] dv;
    logic [5:0]            neg;
    logic [2:0]            par;
    logic [2:0]            par_rej;
    logic [8:0][15:0]      ax;
  } div_t;

  typedef struct packed {
    logic signed [T_W-1:0] tmin;
    logic signed [T_W-1:0] tmax;
    logic [1:0]            hax;
    logic                  hneg;
    logic                  rej;
    logic [5:0][T_W-1:0]   t;
    logic [2:0]            par;
    logic [2:0]            par_rej;
    logic [8:0][15:0]      ax;
  } slab_t;

  // Take the low bits of a coordinate as a signed value of 32 - sh bits
  function automatic logic signed [31:0] sext_cw(input logic [31:0] v, input int unsigned sh);
    logic signed [31:0] u;
    u = $signed(v << sh);
    return u >>> sh;
  endfunction

endpackage

// ===== sv/drob_front.sv =====
// ----------------------------------------------------------------------------
// drob_front: box axis and local origin front end
// Builds the rotated axes from the quaternion, moves the ray origin into box
// space and sets up the six slab divisions for the divider row.
// ----------------------------------------------------------------------------
module drob_front #(
  parameter int COORD_WIDTH = drob_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        size_x,
  input  logic [30:0]        size_y,
  input  logic [30:0]        size_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic [31:0]        ray_origin_x,
  input  logic [31:0]        ray_origin_y,
  input  logic [31:0]        ray_origin_z,
  input  logic [30:0]        foot_radius,
  output logic               div_valid,
  output drob_pkg::div_t     div_data,
  input  logic               div_ready
);
  import drob_pkg::*;

  localparam int CW = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
  localparam int unsigned CW_SHIFT = 32 - CW;
  localparam logic signed [33:0] SAT_HI = 34'(ONE_Q14);
  localparam logic signed [33:0] SAT_LO = -34'(ONE_Q14);

  function automatic logic [15:0] sat_q14(input logic signed [33:0] v);
    if (v > SAT_HI) begin
      return 16'(ONE_Q14);
    end else if (v < SAT_LO) begin
      return 16'(-ONE_Q14);
    end
    return v[15:0];
  endfunction

  logic [4:0] v;
  logic [4:0] rdy;

  // Stage A: relative origin, widened extents, quaternion products
  logic signed [32:0] a_rel [3];
  logic [33:0]        a_e [3];
  logic signed [33:0] a_p [9];
  logic signed [32:0] a_rel_next [3];
  logic [33:0]        a_e_next [3];
  logic signed [33:0] a_p_next [9];

  // Stage B: axes
  logic signed [32:0] b_rel [3];
  logic [33:0]        b_e [3];
  logic [8:0][15:0]   b_ax;
  logic [8:0][15:0]   b_ax_next;

  // Stage C: axis times relative origin
  logic signed [48:0] c_m [9];
  logic signed [48:0] c_m_next [9];
  logic [33:0]        c_e [3];
  logic [8:0][15:0]   c_ax;

  // Stage D: local origin and slab numerators
  logic signed [37:0] d_n1 [3];
  logic signed [37:0] d_n2 [3];
  logic signed [15:0] d_d [3];
  logic [2:0]         d_par;
  logic [2:0]         d_prej;
  logic [8:0][15:0]   d_ax;
  logic signed [37:0] d_n1_next [3];
  logic signed [37:0] d_n2_next [3];
  logic signed [15:0] d_d_next [3];
  logic [2:0]         d_par_next;
  logic [2:0]         d_prej_next;

  // Stage E: divider setup
  div_t e_data;
  div_t e_data_next;

  assign rdy[4] = ~v[4] | div_ready;
  assign rdy[3] = ~v[3] | rdy[4];
  assign rdy[2] = ~v[2] | rdy[3];
  assign rdy[1] = ~v[1] | rdy[2];
  assign rdy[0] = ~v[0] | rdy[1];
  assign in_ready  = rdy[0];
  assign div_valid = v[4];
  assign div_data  = e_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
    end
  end

  always_comb begin
    logic signed [31:0] ro [3];
    logic signed [31:0] cc [3];
    logic signed [33:0] qw, qx, qy, qz;
    ro[0] = sext_cw(ray_origin_x, CW_SHIFT);
    ro[1] = sext_cw(ray_origin_y, CW_SHIFT);
    ro[2] = sext_cw(ray_origin_z, CW_SHIFT);
    cc[0] = sext_cw(center_x, CW_SHIFT);
    cc[1] = sext_cw(center_y, CW_SHIFT);
    cc[2] = sext_cw(center_z, CW_SHIFT);
    for (int i = 0; i < 3; i++) begin
      a_rel_next[i] = 33'(ro[i]) - 33'(cc[i]);
    end
    a_e_next[0] = 34'(size_x) + 34'({foot_radius, 1'b0});
    a_e_next[1] = 34'(size_y);
    a_e_next[2] = 34'(size_z) + 34'({foot_radius, 1'b0});
    qw = 34'(quat_w);
    qx = 34'(quat_x);
    qy = 34'(quat_y);
    qz = 34'(quat_z);
    a_p_next[0] = qy * qy + qz * qz;
    a_p_next[1] = qx * qy + qw * qz;
    a_p_next[2] = qx * qz - qw * qy;
    a_p_next[3] = qx * qy - qw * qz;
    a_p_next[4] = qx * qx + qz * qz;
    a_p_next[5] = qy * qz + qw * qx;
    a_p_next[6] = qx * qz + qw * qy;
    a_p_next[7] = qy * qz - qw * qx;
    a_p_next[8] = qx * qx + qy * qy;
  end

  always_comb begin
    logic signed [33:0] r;
    for (int k = 0; k < 9; k++) begin
      r = (a_p[k] + 34'sd4096) >>> 13;
      // diagonal entries are one minus twice the product sum
      if (k == 0 || k == 4 || k == 8) begin
        b_ax_next[k] = sat_q14(34'(ONE_Q14) - r);
      end else begin
        b_ax_next[k] = sat_q14(r);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c_m_next[i*3+j] = 49'(b_rel[j]) * 49'($signed(b_ax[i*3+j]));
      end
    end
  end

  always_comb begin
    logic signed [50:0] s;
    logic signed [50:0] sr;
    logic signed [37:0] o;
    logic signed [37:0] e38;
    for (int i = 0; i < 3; i++) begin
      s   = 51'(c_m[i*3]) + 51'(c_m[i*3+1]) + 51'(c_m[i*3+2]);
      sr  = (s + 51'sd4096) >>> 13;
      o   = sr[37:0];
      e38 = $signed({4'b0, c_e[i]});
      d_n1_next[i]   = -e38 - o;
      d_n2_next[i]   = e38 - o;
      d_d_next[i]    = -$signed(c_ax[i*3+1]);
      d_par_next[i]  = (c_ax[i*3+1] == 16'h0000);
      d_prej_next[i] = d_par_next[i] & ((o < -e38) | (o > e38));
    end
  end

  always_comb begin
    logic signed [37:0] n;
    logic [37:0]        mag;
    logic signed [15:0] dd;
    logic [15:0]        dmag;
    e_data_next.ax      = d_ax;
    e_data_next.par     = d_par;
    e_data_next.par_rej = d_prej;
    for (int i = 0; i < 3; i++) begin
      dd   = d_d[i];
      dmag = dd[15] ? 16'(-dd) : 16'(dd);
      e_data_next.dv[i] = dmag[DIV_W-1:0];
    end
    for (int l = 0; l < 6; l++) begin
      n   = l[0] ? d_n2[l/2] : d_n1[l/2];
      mag = n[37] ? 38'(-n) : 38'(n);
      // numerator is scaled by 2^13 before the division
      e_data_next.num[l] = {mag[35:0], 13'b0};
      e_data_next.rem[l] = '0;
      e_data_next.neg[l] = n[37] ^ d_d[l/2][15];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_rel <= a_rel_next;
      a_e   <= a_e_next;
      a_p   <= a_p_next;
    end
    if (rdy[1]) begin
      b_rel <= a_rel;
      b_e   <= a_e;
      b_ax  <= b_ax_next;
    end
    if (rdy[2]) begin
      c_m  <= c_m_next;
      c_e  <= b_e;
      c_ax <= b_ax;
    end
    if (rdy[3]) begin
      d_n1   <= d_n1_next;
      d_n2   <= d_n2_next;
      d_d    <= d_d_next;
      d_par  <= d_par_next;
      d_prej <= d_prej_next;
      d_ax   <= c_ax;
    end
    if (rdy[4]) begin
      e_data <= e_data_next;
    end
  end

endmodule

// ===== sv/drob_div_cell.sv =====
// ----------------------------------------------------------------------------
// drob_div_cell: one quotient bit of the slab divider row
// Each cell retires one restoring division step on all six lanes and hands
// the partial quotient and remainder to its neighbor.
// ----------------------------------------------------------------------------
module drob_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  drob_pkg::div_t in_data,
  output logic           out_valid,
  output drob_pkg::div_t out_data,
  input  logic           out_ready
);
  import drob_pkg::*;

  div_t data_next;

  assign in_ready = ~out_valid | out_ready;

  always_comb begin
    logic [REM_W-1:0] rem_s;
    logic             ge;
    data_next = in_data;
    for (int l = 0; l < 6; l++) begin
      rem_s = {in_data.rem[l][REM_W-2:0], in_data.num[l][NUM_W-1]};
      ge    = rem_s >= REM_W'(in_data.dv[l/2]);
      data_next.rem[l] = ge ? rem_s - REM_W'(in_data.dv[l/2]) : rem_s;
      data_next.num[l] = {in_data.num[l][NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== sv/drob_back.sv =====
// ----------------------------------------------------------------------------
// drob_back: slab interval and result stage
// Turns quotients into floored slab distances, walks the three axes in
// order to narrow the hit interval, then forms the hit point and normal.
// ----------------------------------------------------------------------------
module drob_back #(
  parameter int COORD_WIDTH = drob_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               div_valid,
  output logic               div_ready,
  input  drob_pkg::div_t     div_data,
  input  logic [31:0]        ray_origin_x,
  input  logic [31:0]        ray_origin_y,
  input  logic [31:0]        ray_origin_z,
  input  logic [30:0]        ray_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic [30:0]        distance,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z
);
  import drob_pkg::*;

  localparam int CW = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
  localparam int unsigned CW_SHIFT = 32 - CW;
  localparam logic signed [33:0] PY_MAX = 34'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [33:0] PY_MIN = -PY_MAX - 34'sd1;

  function automatic slab_t slab_step(input slab_t s, input int ax_i);
    slab_t                 r;
    logic signed [T_W-1:0] t1;
    logic signed [T_W-1:0] t2;
    logic                  sneg;
    r = s;
    if (!s.rej) begin
      if (s.par[ax_i]) begin
        // axis parallel to the ray: origin must lie within the slab
        if (s.par_rej[ax_i]) r.rej = 1'b1;
      end else begin
        t1   = $signed(s.t[2*ax_i]);
        t2   = $signed(s.t[2*ax_i+1]);
        sneg = 1'b1;
        if (t1 > t2) begin
          t1   = $signed(s.t[2*ax_i+1]);
          t2   = $signed(s.t[2*ax_i]);
          sneg = 1'b0;
        end
        if (t1 > r.tmin) begin
          r.tmin = t1;
          r.hax  = 2'(ax_i);
          r.hneg = sneg;
        end
        if (t2 < r.tmax) r.tmax = t2;
        if (r.tmin > r.tmax) r.rej = 1'b1;
      end
    end
    return r;
  endfunction

  logic [4:0] v;
  logic [4:0] rdy;
  slab_t      st [4];
  slab_t      st_next [4];
  logic signed [T_W-1:0] rl_s;

  logic               hit_next;
  logic [30:0]        distance_next;
  logic signed [31:0] point_x_next;
  logic signed [31:0] point_y_next;
  logic signed [31:0] point_z_next;
  logic signed [15:0] normal_x_next;
  logic signed [15:0] normal_y_next;
  logic signed [15:0] normal_z_next;

  assign rl_s = $signed(T_W'(ray_length));

  assign rdy[4] = ~v[4] | ~out_stall;
  assign rdy[3] = ~v[3] | rdy[4];
  assign rdy[2] = ~v[2] | rdy[3];
  assign rdy[1] = ~v[1] | rdy[2];
  assign rdy[0] = ~v[0] | rdy[1];
  assign div_ready = rdy[0];
  assign out_valid = v[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= div_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
    end
  end

  // Floor correction: a negative quotient with a remainder drops by one
  always_comb begin
    logic signed [T_W-1:0] qs;
    st_next[0].tmin    = '0;
    st_next[0].tmax    = rl_s;
    st_next[0].hax     = AXIS_NONE;
    st_next[0].hneg    = 1'b0;
    st_next[0].rej     = 1'b0;
    st_next[0].par     = div_data.par;
    st_next[0].par_rej = div_data.par_rej;
    st_next[0].ax      = div_data.ax;
    for (int l = 0; l < 6; l++) begin
      qs = $signed({1'b0, div_data.num[l]});
      if (div_data.neg[l]) begin
        st_next[0].t[l] = -qs - T_W'(div_data.rem[l] != '0);
      end else begin
        st_next[0].t[l] = qs;
      end
    end
    for (int i = 0; i < 3; i++) begin
      st_next[i+1] = slab_step(st[i], i);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (rdy[k]) st[k] <= st_next[k];
    end
  end

  always_comb begin
    logic signed [15:0] rx, ry, rz;
    logic signed [15:0] nx, ny, nz;
    logic               nohit;
    logic               deg;
    logic [1:0]         nzc;
    logic signed [31:0] ro_y;
    logic signed [33:0] py;
    slab_t              s;
    s = st[3];
    case (s.hax)
      2'd1: begin
        rx = $signed(s.ax[3]); ry = $signed(s.ax[4]); rz = $signed(s.ax[5]);
      end
      2'd2: begin
        rx = $signed(s.ax[6]); ry = $signed(s.ax[7]); rz = $signed(s.ax[8]);
      end
      default: begin
        rx = $signed(s.ax[0]); ry = $signed(s.ax[1]); rz = $signed(s.ax[2]);
      end
    endcase
    nx = s.hneg ? -rx : rx;
    ny = s.hneg ? -ry : ry;
    nz = s.hneg ? -rz : rz;
    nzc = 2'(nx != 16'sd0) + 2'(ny != 16'sd0) + 2'(nz != 16'sd0);
    // tiny normal: squared length of two raw units or less
    deg = (nx == 16'sd0 || nx == 16'sd1 || nx == -16'sd1) &&
          (ny == 16'sd0 || ny == 16'sd1 || ny == -16'sd1) &&
          (nz == 16'sd0 || nz == 16'sd1 || nz == -16'sd1) && (nzc != 2'd3);
    if (deg) begin
      nx = 16'sd0;
      ny = 16'(ONE_Q14);
      nz = 16'sd0;
    end
    nohit = s.rej || (s.tmin < 0) || (s.tmin > rl_s) || (s.hax == AXIS_NONE);
    ro_y = sext_cw(ray_origin_y, CW_SHIFT);
    py   = 34'(ro_y) - 34'(s.tmin[30:0]);
    if (py > PY_MAX) py = PY_MAX;
    if (py < PY_MIN) py = PY_MIN;
    hit_next      = ~nohit;
    distance_next = nohit ? '0 : s.tmin[30:0];
    point_x_next  = nohit ? '0 : sext_cw(ray_origin_x, CW_SHIFT);
    point_y_next  = nohit ? '0 : py[31:0];
    point_z_next  = nohit ? '0 : sext_cw(ray_origin_z, CW_SHIFT);
    normal_x_next = nohit ? '0 : nx;
    normal_y_next = nohit ? '0 : ny;
    normal_z_next = nohit ? '0 : nz;
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      hit      <= hit_next;
      distance <= distance_next;
      point_x  <= point_x_next;
      point_y  <= point_y_next;
      point_z  <= point_z_next;
      normal_x <= normal_x_next;
      normal_y <= normal_y_next;
      normal_z <= normal_z_next;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> distance == '0 && normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("miss transaction carries nonzero payload");

  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> distance != '0 && distance <= ray_length)
    else $error("hit distance outside the ray");

  a_hit_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> (normal_x != '0 || normal_y != '0 || normal_z != '0))
    else $error("hit with zero normal");

endmodule

// ===== sv/downward_ray_oriented_box_hit_unit.sv =====
// ----------------------------------------------------------------------------
// downward_ray_oriented_box_hit_unit: downward ray against oriented boxes
// Takes one box per transaction and returns one hit record per box.
// ----------------------------------------------------------------------------
// The path from an accepted box to its result runs through 5 front stages,
//   49 divider cells and 5 slab and result stages.
// Throughput: one box per cycle unless stalled; the divider row is one cell per quotient bit.
// A stall holds only the filled stages behind it; empty stages keep filling.
// Reset clears all stage valid bits and loads the ray registers with their
//   defaults (origin zero, length 65536, radius zero).
module downward_ray_oriented_box_hit_unit #(
  parameter int COORD_WIDTH = drob_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        size_x,
  input  logic [30:0]        size_y,
  input  logic [30:0]        size_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic [30:0]        distance,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z
);
  import drob_pkg::*;

  logic [31:0] ray_origin_x;
  logic [31:0] ray_origin_y;
  logic [31:0] ray_origin_z;
  logic [30:0] ray_length;
  logic [30:0] foot_radius;

  logic front_ready;
  logic cell_valid [NUM_W+1];
  logic cell_ready [NUM_W+1];
  div_t cell_data  [NUM_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_origin_x <= '0;
      ray_origin_y <= '0;
      ray_origin_z <= '0;
      ray_length   <= 31'd65536;
      foot_radius  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORIGIN_X:    ray_origin_x <= cfg_data;
        REG_ORIGIN_Y:    ray_origin_y <= cfg_data;
        REG_ORIGIN_Z:    ray_origin_z <= cfg_data;
        REG_RAY_LENGTH:  ray_length   <= cfg_data[30:0];
        REG_FOOT_RADIUS: foot_radius  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign in_stall = ~front_ready;

  drob_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (front_ready),
    .center_x     (center_x),
    .center_y     (center_y),
    .center_z     (center_z),
    .size_x       (size_x),
    .size_y       (size_y),
    .size_z       (size_z),
    .quat_w       (quat_w),
    .quat_x       (quat_x),
    .quat_y       (quat_y),
    .quat_z       (quat_z),
    .ray_origin_x (ray_origin_x),
    .ray_origin_y (ray_origin_y),
    .ray_origin_z (ray_origin_z),
    .foot_radius  (foot_radius),
    .div_valid    (cell_valid[0]),
    .div_data     (cell_data[0]),
    .div_ready    (cell_ready[0])
  );

  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    drob_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[k]),
      .in_ready  (cell_ready[k]),
      .in_data   (cell_data[k]),
      .out_valid (cell_valid[k+1]),
      .out_data  (cell_data[k+1]),
      .out_ready (cell_ready[k+1])
    );
  end

  drob_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .div_valid    (cell_valid[NUM_W]),
    .div_ready    (cell_ready[NUM_W]),
    .div_data     (cell_data[NUM_W]),
    .ray_origin_x (ray_origin_x),
    .ray_origin_y (ray_origin_y),
    .ray_origin_z (ray_origin_z),
    .ray_length   (ray_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .distance     (distance),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z)
  );

endmodule
